// ===== rtl/mfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mfp_pkg: shared types and constants
// Holds the law codes, field widths, register indexes and the struct types
// that pass between the front and back parts of the motion profile block.
// ----------------------------------------------------------------------------
package mfp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int POS_W = 32;
	localparam int FREQ_W = 32;
	localparam int LAW_W = 3;
	localparam int RANGE_W = 31;
	localparam int DIFF_W = 33;
	localparam int QDEPTH = 4;

	typedef enum logic [LAW_W-1:0] {
		LAW_IDLE = 3'd0,
		LAW_FLAT = 3'd1,
		LAW_POW2 = 3'd2,
		LAW_POW4 = 3'd3,
		LAW_POW8 = 3'd4,
		LAW_QUARTER = 3'd5
	} law_t;

	localparam logic [2:0] REG_MAIN_FREQ = 3'd0;
	localparam logic [2:0] REG_START = 3'd1;
	localparam logic [2:0] REG_STOP = 3'd2;
	localparam logic [2:0] REG_DIR = 3'd3;
	localparam logic [2:0] REG_ACCEL = 3'd4;
	localparam logic [2:0] REG_DECEL = 3'd5;
	localparam logic [2:0] REG_MIN_RANGE = 3'd6;

	// Settings that both parts read.
	typedef struct packed {
		logic [FREQ_W-1:0] main_frequency;
		logic signed [POS_W-1:0] start_position;
		logic signed [POS_W-1:0] stop_position;
		logic move_direction;
		law_t accel_law;
		law_t decel_law;
		logic [RANGE_W-1:0] min_range;
	} cfg_t;

	// Classified sample handed from front to back.
	typedef struct packed {
		logic [DIFF_W-2:0] abs_d;
		logic [DIFF_W-2:0] abs_r;
		logic zero_x;
		logic full_x;
		logic creep;
	} cls_t;

	function automatic law_t sat_law(input logic [LAW_W-1:0] v);
		law_t l;
		if (v > LAW_QUARTER) begin
			l = LAW_QUARTER;
		end else begin
			l = law_t'(v);
		end
		return l;
	endfunction

endpackage

// ===== rtl/mfp_if.sv =====
// ----------------------------------------------------------------------------
// mfp_if: valid/ready channel
// Carries one item of WIDTH payload bits between a source and a sink.
// ----------------------------------------------------------------------------
interface mfp_if #(
	parameter int WIDTH = 32
);
	logic valid;
	logic ready;
	logic [WIDTH-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/motion_frequency_profile.sv =====
// ----------------------------------------------------------------------------
// motion_frequency_profile: travel-shaped frequency command
// Throughput: one sample per cycle unless the result sink stalls;
// the back pipeline has one quotient bit per stage, so the divider
// never stalls the flow.
// Reset: arst_n clears the registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module motion_frequency_profile #(
	parameter int FRAC_BITS = mfp_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	mfp_if.sink sample,
	mfp_if.source result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import mfp_pkg::*;

	cfg_t cfg_q;
	logic wr;
	logic [2:0] idx;

	// Registers sit at byte address 4*i.
	assign idx = paddr[4:2];
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_MAIN_FREQ: cfg_q.main_frequency <= pwdata;
				REG_START: cfg_q.start_position <= pwdata;
				REG_STOP: cfg_q.stop_position <= pwdata;
				REG_DIR: cfg_q.move_direction <= pwdata[0];
				REG_ACCEL: cfg_q.accel_law <= sat_law(pwdata[2:0]);
				REG_DECEL: cfg_q.decel_law <= sat_law(pwdata[2:0]);
				REG_MIN_RANGE: cfg_q.min_range <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAIN_FREQ: prdata = cfg_q.main_frequency;
			REG_START: prdata = cfg_q.start_position;
			REG_STOP: prdata = cfg_q.stop_position;
			REG_DIR: prdata = {31'd0, cfg_q.move_direction};
			REG_ACCEL: prdata = {29'd0, cfg_q.accel_law};
			REG_DECEL: prdata = {29'd0, cfg_q.decel_law};
			REG_MIN_RANGE: prdata = {1'b0, cfg_q.min_range};
			default: prdata = '0;
		endcase
	end

	// Front part: classify the sample against the configured move.
	logic f_valid, f_ready, b_valid, b_ready, o_valid;
	cls_t f_cls, b_cls;

	mfp_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(sample.valid), .in_ready(sample.ready), .in_pos(sample.data),
		.out_valid(f_valid), .out_ready(f_ready), .out_cls(f_cls)
	);

	// Short queue so the front keeps accepting while the back stalls, until the queue is full.
	mfp_queue #(.WIDTH($bits(cls_t)), .DEPTH(QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_cls),
		.out_valid(b_valid), .out_ready(b_ready), .out_data(b_cls)
	);

	logic [FREQ_W-1:0] freq;
	logic dir, dec;
	law_t law;

	// Back part: divide, shape and scale.
	mfp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(b_valid), .in_ready(b_ready), .in_cls(b_cls),
		.out_valid(o_valid), .out_ready(result.ready),
		.frequency(freq), .direction_out(dir), .active_law(law),
		.decelerating(dec)
	);

	assign result.valid = o_valid;
	assign result.data = {dec, law, dir, freq};
endmodule

// ===== rtl/mfp_front.sv =====
// ----------------------------------------------------------------------------
// mfp_front: sample classifier
// Registers each accepted sample, forms the travel and range magnitudes and
// flags the cases that need no division.
// ----------------------------------------------------------------------------
module mfp_front (
	input logic clk,
	input logic arst_n,
	input mfp_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input logic signed [mfp_pkg::POS_W-1:0] in_pos,
	output logic out_valid,
	input logic out_ready,
	output mfp_pkg::cls_t out_cls
);
	import mfp_pkg::*;

	logic signed [DIFF_W-1:0] d, r;
	logic [DIFF_W-2:0] ad, ar;
	cls_t cls;

	always_comb begin
		d = DIFF_W'(in_pos) - DIFF_W'(cfg.start_position);
		r = DIFF_W'(cfg.stop_position) - DIFF_W'(cfg.start_position);
		ad = d[DIFF_W-1] ? (DIFF_W-1)'(-d) : d[DIFF_W-2:0];
		ar = r[DIFF_W-1] ? (DIFF_W-1)'(-r) : r[DIFF_W-2:0];
		cls.abs_d = ad;
		cls.abs_r = ar;
		cls.creep = ar < (DIFF_W-1)'(cfg.min_range);
		cls.full_x = 1'b0;
		cls.zero_x = 1'b0;
		if (r == '0) begin
			cls.full_x = !d[DIFF_W-1];
			cls.zero_x = d[DIFF_W-1];
		end else if (d == '0 || (d[DIFF_W-1] != r[DIFF_W-1])) begin
			cls.zero_x = 1'b1;
		end else if (ad >= ar) begin
			cls.full_x = 1'b1;
		end
	end

	assign in_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_cls <= cls;
		end
	end
endmodule

// ===== rtl/mfp_queue.sv =====
// ----------------------------------------------------------------------------
// mfp_queue: small register queue
// Decouples the classifier from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module mfp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [WIDTH-1:0] in_data,
	output logic out_valid,
	input logic out_ready,
	output logic [WIDTH-1:0] out_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_data;
		end
	end
endmodule

// ===== rtl/mfp_back.sv =====
// ----------------------------------------------------------------------------
// mfp_back: divider and law pipeline
// A radix-2 restoring divider, one quotient bit per stage, followed by the
// midtravel fold, three squaring stages, the law select and the final scale.
// ----------------------------------------------------------------------------
module mfp_back #(
	parameter int FRAC_BITS = mfp_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input mfp_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input mfp_pkg::cls_t in_cls,
	output logic out_valid,
	input logic out_ready,
	output logic [mfp_pkg::FREQ_W-1:0] frequency,
	output logic direction_out,
	output mfp_pkg::law_t active_law,
	output logic decelerating
);
	import mfp_pkg::*;

	localparam int F = FRAC_BITS;
	localparam int XW = F + 1;
	localparam int RW = DIFF_W - 1;
	localparam int NS = F + 7;

	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// Divider: the remainder stays below the divisor, so RW+1 bits suffice.
	logic [NS-1:0] v_q;
	logic [RW:0] rem_q [F+1];
	logic [RW-1:0] dvs_q [F+1];
	logic [F-1:0] quo_q [F+1];
	logic [1:0] flg_q [F+1];
	logic crp_q [F+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q[0] <= {1'b0, in_cls.abs_d};
			dvs_q[0] <= in_cls.abs_r;
			quo_q[0] <= '0;
			flg_q[0] <= {in_cls.full_x, in_cls.zero_x};
			crp_q[0] <= in_cls.creep;
		end
	end

	for (genvar i = 0; i < F; i++) begin : g_div
		logic [RW+1:0] sh;
		logic [RW+1:0] df;
		assign sh = {rem_q[i], 1'b0};
		assign df = sh - {2'b00, dvs_q[i]};
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[i+1] <= df[RW+1] ? sh[RW:0] : df[RW:0];
				quo_q[i+1] <= {quo_q[i][F-2:0], !df[RW+1]};
				dvs_q[i+1] <= dvs_q[i];
				flg_q[i+1] <= flg_q[i];
				crp_q[i+1] <= crp_q[i];
			end
		end
	end

	// Fold around midtravel and pick the law.
	logic [XW-1:0] x;
	logic [XW-1:0] x1_s1, x2_s2, x4_s3, t_s2, x1_s2;
	logic dec_s1, dec_s2, dec_s3, dec_s4;
	law_t law_s1, law_s2, law_s3, law_s4;
	logic qflat_s2, qflat_s3, qflat_s4;
	logic [XW-1:0] tq_s3, x8_s4, y_s4, x2b_s3, x4b_s4, x1b_s3, tq_s4;
	logic [XW+3:0] ten_x1;
	logic [2*XW-1:0] p1, p2, p3, p4;
	logic [FREQ_W+XW-1:0] fp;

	always_comb begin
		if (flg_q[F][1]) begin
			x = XW'(1) << F;
		end else if (flg_q[F][0]) begin
			x = '0;
		end else begin
			x = {1'b0, quo_q[F]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s1 <= x[F] | x[F-1];
			x1_s1 <= (x[F] | x[F-1]) ? XW'({x, 1'b0} - (XW+1)'(1 << F))
				: XW'((XW+1)'(1 << F) - {x, 1'b0});
			law_s1 <= crp_q[F] ? LAW_IDLE
				: ((x[F] | x[F-1]) ? cfg.decel_law : cfg.accel_law);
		end
	end

	assign ten_x1 = (XW+4)'(x1_s1) * (XW+4)'(10);
	assign p1 = (2*XW)'(x1_s1) * (2*XW)'(x1_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			x2_s2 <= XW'(p1 >> F);
			qflat_s2 <= ten_x1 < (XW+4)'(9) << F;
			t_s2 <= XW'(ten_x1 - ((XW+4)'(9) << F));
			x1_s2 <= x1_s1;
			dec_s2 <= dec_s1;
			law_s2 <= law_s1;
		end
	end

	assign p2 = (2*XW)'(x2_s2) * (2*XW)'(x2_s2);
	assign p4 = (2*XW)'(t_s2) * (2*XW)'(t_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			x4_s3 <= XW'(p2 >> F);
			tq_s3 <= XW'(p4 >> F);
			x2b_s3 <= x2_s2;
			x1b_s3 <= x1_s2;
			qflat_s3 <= qflat_s2;
			dec_s3 <= dec_s2;
			law_s3 <= law_s2;
		end
	end

	assign p3 = (2*XW)'(x4_s3) * (2*XW)'(x4_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			x8_s4 <= XW'(p3 >> F);
			x4b_s4 <= x4_s3;
			tq_s4 <= tq_s3;
			qflat_s4 <= qflat_s3;
			dec_s4 <= dec_s3;
			law_s4 <= law_s3;
		end
	end

	// x1b_s3 is only needed to keep pow2 aligned; its square is x2b_s3.
	logic [XW-1:0] x2c_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			x2c_s4 <= (x1b_s3 == '0) ? '0 : x2b_s3;
		end
	end

	always_comb begin
		case (law_s4)
			LAW_FLAT: y_s4 = XW'(1) << F;
			LAW_POW2: y_s4 = (XW'(1) << F) - x2c_s4;
			LAW_POW4: y_s4 = (XW'(1) << F) - x4b_s4;
			LAW_POW8: y_s4 = (XW'(1) << F) - x8_s4;
			LAW_QUARTER: y_s4 = qflat_s4 ? (XW'(1) << F) : (XW'(1) << F) - tq_s4;
			default: y_s4 = '0;
		endcase
	end

	logic [XW-1:0] y_s5;
	logic dec_s5;
	law_t law_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			y_s5 <= y_s4;
			dec_s5 <= dec_s4;
			law_s5 <= law_s4;
		end
	end

	assign fp = (FREQ_W+XW)'(cfg.main_frequency) * (FREQ_W+XW)'(y_s5);

	assign out_valid = v_q[NS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			frequency <= FREQ_W'(fp >> F);
			direction_out <= cfg.move_direction;
			active_law <= law_s5;
			decelerating <= dec_s5;
		end
	end
endmodule

// ===== rtl/mfp_checker.sv =====
// ----------------------------------------------------------------------------
// mfp_checker: port-level checks
// Watches the result channel and the register port of the top level.
// ----------------------------------------------------------------------------
module mfp_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic [36:0] res_data,
	input logic pready
);
	import mfp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	a_law: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data[35:33] <= LAW_QUARTER)
		else $error("law code out of range");

	a_creep: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data[35:33] == LAW_IDLE |-> res_data[31:0] == '0)
		else $error("creep with nonzero frequency");

	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");
endmodule

bind motion_frequency_profile mfp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .res_valid(result.valid),
	.res_ready(result.ready), .res_data(result.data), .pready(pready)
);

// ===== test/motion_frequency_profile_tb.sv =====
// ----------------------------------------------------------------------------
// motion_frequency_profile_tb: self-checking bench for the frequency profile
// Programs the move registers over the APB port and streams encoder samples
// into the block. Each sample is predicted in the bench from the current
// register copy, and every result is compared field by field in order.
// ----------------------------------------------------------------------------
module motion_frequency_profile_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mfp_pkg::*;

	localparam int FRAC = 16;
	localparam longint ONE = longint'(1) << FRAC;
	localparam longint HALF = longint'(1) << (FRAC - 1);
	// Settling wait after the last result, with some margin over the pipeline.
	localparam int SETTLE = FRAC + 20;
	localparam int CYCLE_LIMIT = 400000;

	// One result item; the first field listed sits in the highest bits.
	typedef struct packed {
		logic decelerating;
		law_t active_law;
		logic direction_out;
		logic [FREQ_W-1:0] frequency;
	} profile_point_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	mfp_if #(.WIDTH(POS_W)) sample_ch ();
	mfp_if #(.WIDTH($bits(profile_point_t))) result_ch ();

	motion_frequency_profile u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch.sink),
		.result(result_ch.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// The bench keeps its own copy of every register, updated on each write.
	logic [31:0] peak_freq;
	longint move_start;
	longint move_stop;
	logic dir_flag;
	law_t accel_sel;
	law_t decel_sel;
	logic [30:0] short_limit;

	profile_point_t expected_points[$];
	int error_count;
	int cycle_count;
	int burst_left;

	// The clock runs free with an 8 ns period.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A hard ceiling on run length so a hung handshake cannot stall the run.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("mismatch on %s: got %0d, expected %0d (time %0t)", field, got, want, $realtime);
		error_count++;
	endtask

	// Law codes above five are clipped to the quarter law when written.
	function automatic law_t clip_law(input logic [31:0] value);
		law_t l;
		if (value[2:0] > LAW_QUARTER) begin
			l = LAW_QUARTER;
		end else begin
			l = law_t'(value[2:0]);
		end
		return l;
	endfunction

	// Works out the commanded frequency for one encoder sample from the
	// register copy: progress, distance from midtravel, then the law.
	function automatic profile_point_t profile_at(input logic [31:0] pos_bits);
		profile_point_t p;
		longint pos;
		longint d;
		longint r;
		longint ad;
		longint ar;
		longint x;
		longint x1;
		longint x2;
		longint x4;
		longint t;
		longint y;
		law_t law;
		logic decel;
		pos = longint'($signed(pos_bits));
		d = pos - move_start;
		r = move_stop - move_start;
		ad = (d < 0) ? -d : d;
		ar = (r < 0) ? -r : r;
		// A zero range counts as finished once the sample reaches the start.
		if (r == 0) begin
			x = (d >= 0) ? ONE : 0;
		end else if (d == 0 || ((d > 0) != (r > 0))) begin
			x = 0;
		end else if (ad >= ar) begin
			x = ONE;
		end else begin
			x = (ad << FRAC) / ar;
		end
		decel = (x >= HALF);
		x1 = decel ? (2 * x - ONE) : (ONE - 2 * x);
		// A move shorter than the minimum range always creeps.
		if (ar < longint'(short_limit)) begin
			law = LAW_IDLE;
		end else begin
			law = decel ? decel_sel : accel_sel;
		end
		case (law)
			LAW_FLAT: y = ONE;
			LAW_POW2: y = ONE - ((x1 * x1) >> FRAC);
			LAW_POW4: begin
				x2 = (x1 * x1) >> FRAC;
				y = ONE - ((x2 * x2) >> FRAC);
			end
			LAW_POW8: begin
				x2 = (x1 * x1) >> FRAC;
				x4 = (x2 * x2) >> FRAC;
				y = ONE - ((x4 * x4) >> FRAC);
			end
			LAW_QUARTER: begin
				// Flat until x1 reaches 0.9, then a quadratic fall to zero.
				if (10 * x1 < 9 * ONE) begin
					y = ONE;
				end else begin
					t = 10 * x1 - 9 * ONE;
					y = ONE - ((t * t) >> FRAC);
				end
			end
			default: y = 0;
		endcase
		p.frequency = 32'((longint'(peak_freq) * y) >> FRAC);
		p.direction_out = dir_flag;
		p.active_law = law;
		p.decelerating = decel;
		return p;
	endfunction

	// The sender runs in bursts; between bursts valid drops for a random gap.
	// Valid is only lowered when a real gap follows, so it never toggles
	// twice in one step.
	task automatic send_sample(input logic [31:0] pos);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data <= pos;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		expected_points.push_back(profile_at(pos));
		burst_left--;
	endtask

	// Stops the sender and waits until every expected result is back and
	// the pipeline has had time to empty.
	task automatic drain;
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_points.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Two-phase APB write; the copy is updated at the access edge, and the bus
	// goes idle afterwards so back-to-back writes each get their setup phase.
	task automatic write_reg(input int idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_MAIN_FREQ: peak_freq = value;
			REG_START: move_start = longint'($signed(value));
			REG_STOP: move_stop = longint'($signed(value));
			REG_DIR: dir_flag = value[0];
			REG_ACCEL: accel_sel = clip_law(value);
			REG_DECEL: decel_sel = clip_law(value);
			REG_MIN_RANGE: short_limit = value[30:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_move(input logic [31:0] freq, input logic [31:0] start,
			input logic [31:0] stop, input logic dir, input logic [31:0] accel,
			input logic [31:0] decel, input logic [31:0] min_r);
		write_reg(REG_MAIN_FREQ, freq);
		write_reg(REG_START, start);
		write_reg(REG_STOP, stop);
		write_reg(REG_DIR, {31'd0, dir});
		write_reg(REG_ACCEL, accel);
		write_reg(REG_DECEL, decel);
		write_reg(REG_MIN_RANGE, min_r);
	endtask

	// The receiver alternates between always-ready stretches, light random
	// stalls and long stalls; results are checked on every handshake.
	int stall_left;
	int stall_mode;
	initial begin
		stall_left = 0;
		stall_mode = 0;
	end
	always @(posedge clk) begin
		profile_point_t got;
		profile_point_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = profile_point_t'(result_ch.data);
			if (expected_points.size() == 0) begin
				$display("result with no sample outstanding (time %0t)", $realtime);
				error_count++;
			end else begin
				want = expected_points.pop_front();
				if (got.frequency !== want.frequency)
					report_mismatch("frequency", got.frequency, want.frequency);
				if (got.direction_out !== want.direction_out)
					report_mismatch("direction_out", got.direction_out, want.direction_out);
				if (got.active_law !== want.active_law)
					report_mismatch("active_law", got.active_law, want.active_law);
				if (got.decelerating !== want.decelerating)
					report_mismatch("decelerating", got.decelerating, want.decelerating);
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(5, 60);
		end
		stall_left--;
		case (stall_mode)
			0: result_ch.ready <= 1'b1;
			1: result_ch.ready <= ($urandom_range(0, 3) != 0);
			default: result_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// With every register at its reset value the range is zero, so samples
	// at or past zero report full progress and all laws creep.
	task automatic test_reset_state;
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		drain();
	endtask

	// Every law on both halves of a short forward move, with samples before
	// the start, at midtravel, deep in the quarter-law fall and past the end.
	task automatic test_each_law;
		for (int law = LAW_IDLE; law <= LAW_QUARTER; law++) begin
			set_move(32'hFFFF_FFFF, 32'd0, 32'd1000, law[0], law, 5 - law, 32'd0);
			send_sample(-32'sd5);
			send_sample(32'd20);
			send_sample(32'd499);
			send_sample(32'd500);
			send_sample(32'd980);
			send_sample(32'd2000);
			drain();
		end
	endtask

	// Law codes six and seven must be clipped to the quarter law.
	task automatic test_law_clipping;
		set_move(32'h0001_0000, 32'd100, 32'd200, 1'b1, 32'd6, 32'd7, 32'd0);
		send_sample(32'd101);
		send_sample(32'd199);
		drain();
	endtask

	// A move shorter than the minimum range creeps, yet still reports which
	// half of the travel the sample is in.
	task automatic test_short_range;
		set_move(32'h1234_5678, 32'd0, 32'd99, 1'b0, LAW_FLAT, LAW_FLAT, 32'd100);
		send_sample(32'd10);
		send_sample(32'd90);
		drain();
		write_reg(REG_MIN_RANGE, 32'h7FFF_FFFF);
		send_sample(32'd60);
		drain();
	endtask

	// A reverse move and the widest possible span, with extreme samples.
	task automatic test_extremes;
		set_move(32'hFFFF_FFFF, 32'd1000, -32'sd1000, 1'b1, LAW_POW8, LAW_POW4, 32'd0);
		send_sample(32'd0);
		send_sample(-32'sd999);
		send_sample(32'd1001);
		drain();
		set_move(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, LAW_POW2,
			LAW_QUARTER, 32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h0000_0000);
		drain();
		write_reg(REG_MIN_RANGE, 32'd0);
		send_sample(32'h8000_0001);
		send_sample(32'h7FFF_FFFE);
		drain();
	endtask

	// A write beyond the last register must leave every setting untouched.
	task automatic test_unmapped_register;
		write_reg(7, 32'hFFFF_FFFF);
		send_sample(32'h4000_0000);
		drain();
	endtask

	// Random moves: mostly samples inside the move, some anywhere at all.
	// Spans range from tiny to the full encoder range, and now and then the
	// minimum range is set above the span.
	task automatic test_random_moves;
		logic [31:0] start;
		logic [31:0] span;
		logic [31:0] pos;
		logic [31:0] min_r;
		longint lo;
		longint hi;
		for (int phase = 0; phase < 10; phase++) begin
			start = $urandom();
			case ($urandom_range(0, 3))
				0: span = $urandom_range(0, 16);
				1: span = $urandom_range(17, 5000);
				2: span = $urandom_range(5001, 32'h00FF_FFFF);
				default: span = $urandom();
			endcase
			if ($urandom_range(0, 1)) span = -span;
			min_r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6000) : 32'd0;
			set_move($urandom(), start, start + span, 1'($urandom_range(0, 1)),
				$urandom_range(0, 7), $urandom_range(0, 7), min_r);
			lo = longint'($signed(start));
			hi = longint'($signed(start + span));
			if (hi < lo) begin
				lo = hi;
				hi = longint'($signed(start));
			end
			for (int n = 0; n < 48; n++) begin
				if ($urandom_range(0, 5) == 0) begin
					pos = $urandom();
				end else if (hi - lo < 64'h7FFF_FFFF) begin
					pos = 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
				end else begin
					pos = 32'(lo + (longint'($urandom()) * (hi - lo)) / 64'hFFFF_FFFF);
				end
				send_sample(pos);
			end
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		result_ch.ready = 1'b0;
		error_count = 0;
		burst_left = 0;
		peak_freq = '0;
		move_start = 0;
		move_stop = 0;
		dir_flag = 1'b0;
		accel_sel = LAW_IDLE;
		decel_sel = LAW_IDLE;
		short_limit = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_each_law();
		test_law_clipping();
		test_short_range();
		test_extremes();
		test_unmapped_register();
		test_random_moves();

		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mfp_pkg.sv
rtl/mfp_if.sv
rtl/mfp_front.sv
rtl/mfp_queue.sv
rtl/mfp_back.sv
rtl/motion_frequency_profile.sv
rtl/mfp_checker.sv
test/motion_frequency_profile_tb.sv
